// File: rtl/core/itpv_pkg.sv
package itpv_pkg;

   // String layout: YYYY-MM-DDTHH:MM:SSZ
   localparam logic [4:0] STR_LEN   = 5'd20;
   localparam logic [4:0] POS_SAT   = 5'd21;
   localparam logic [4:0] POS_DASH0 = 5'd4;
   localparam logic [4:0] POS_DASH1 = 5'd7;
   localparam logic [4:0] POS_T     = 5'd10;
   localparam logic [4:0] POS_COL0  = 5'd13;
   localparam logic [4:0] POS_COL1  = 5'd16;
   localparam logic [4:0] POS_Z     = 5'd19;
   localparam logic [4:0] POS_YEAR_END   = 5'd3;
   localparam logic [4:0] POS_MONTH_END  = 5'd6;
   localparam logic [4:0] POS_DAY_END    = 5'd9;
   localparam logic [4:0] POS_HOUR_END   = 5'd12;
   localparam logic [4:0] POS_MINUTE_END = 5'd15;

   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [13:0] YEAR_MIN  = 14'd2000;
   localparam logic [13:0] YEAR_MAX  = 14'd2099;
   localparam logic [6:0]  HOUR_MAX  = 7'd23;
   localparam logic [6:0]  MINSEC_MAX = 7'd59;

   // Configuration register indexes
   localparam logic [2:0] CSR_THR_YEAR   = 3'd0;
   localparam logic [2:0] CSR_THR_MONTH  = 3'd1;
   localparam logic [2:0] CSR_THR_DAY    = 3'd2;
   localparam logic [2:0] CSR_THR_HOUR   = 3'd3;
   localparam logic [2:0] CSR_THR_MINUTE = 3'd4;
   localparam logic [2:0] CSR_THR_SECOND = 3'd5;

   // Parsed string as it stands after its final character
   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [4:0]  pos;
      logic        err;
   } snap_type;

   // Synchronization threshold
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } thr_type;

   // Verdict on one string
   typedef struct packed {
      logic ok;
      logic at_or_after;
   } verdict_type;

endpackage

// File: rtl/core/itpv_check.sv
module itpv_check
   import itpv_pkg::*;
(
   input  snap_type    snap,
   input  thr_type     thr,
   output verdict_type verdict
);

   logic       leap;
   logic [6:0] mlen;
   logic       form_ok;
   logic       date_ok;
   logic       time_ok;
   logic       at_or_after;

   // Leap rule: only consulted when the year is 2000..2099, where a multiple
   // of four is always a leap year (2000 is a multiple of 400).
   assign leap = (snap.year[1:0] == 2'b00);

   // Month length
   always_comb begin
      case (snap.month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: mlen = 7'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                     mlen = 7'd30;
         7'd2:    mlen = leap ? 7'd29 : 7'd28;
         default: mlen = 7'd0;
      endcase
   end

   assign form_ok = (snap.pos == STR_LEN) && !snap.err;
   assign date_ok = (snap.year >= YEAR_MIN) && (snap.year <= YEAR_MAX)
                 && (snap.month >= 7'd1) && (snap.month <= 7'd12)
                 && (snap.day >= 7'd1) && (snap.day <= mlen);
   assign time_ok = (snap.hour <= HOUR_MAX) && (snap.minute <= MINSEC_MAX)
                 && (snap.second <= MINSEC_MAX);

   // Lexicographic compare, time against threshold, fields zero-extended
   always_comb begin
      if (snap.year != thr.year) begin
         at_or_after = snap.year > thr.year;
      end else if (snap.month != {3'b000, thr.month}) begin
         at_or_after = snap.month > {3'b000, thr.month};
      end else if (snap.day != {2'b00, thr.day}) begin
         at_or_after = snap.day > {2'b00, thr.day};
      end else if (snap.hour != {2'b00, thr.hour}) begin
         at_or_after = snap.hour > {2'b00, thr.hour};
      end else if (snap.minute != {1'b0, thr.minute}) begin
         at_or_after = snap.minute > {1'b0, thr.minute};
      end else begin
         at_or_after = snap.second >= {1'b0, thr.second};
      end
   end

   assign verdict = '{ok: form_ok && date_ok && time_ok, at_or_after: at_or_after};

endmodule

// File: rtl/core/iso_timestamp_parse_validate.sv
// ISO 8601 UTC timestamp parser (YYYY-MM-DDTHH:MM:SSZ).
// Request channel (req_): one character per request, req_last_char set on the
// final character of a string. A request is taken when req_valid is high and
// req_stall is low. Result channel (rsp_): one result per string, presented
// after the request carrying the final character; the receiver holds it with
// rsp_stall. Characters that are not final give no result.
// A final character passes the input register, then the parse register, then
// the result register before its result shows on rsp_.
// Throughput: one character per cycle while req_stall is low; the accumulate
// step and the date check each sit between two registers, so nothing iterates.
// While the result register is held by rsp_stall, characters keep flowing
// until a second final character has to wait; req_stall then rises.
// Configuration (csr_): threshold registers, index 0..5, always ready; writes
// to indexes above 5 are dropped. Write only while no string is in flight.
// Reset: clears the pipeline, the string state and the synchronized flag, and
// loads the threshold 2000-01-01T00:00:00.
module iso_timestamp_parse_validate
   import itpv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic        rsp_synchronized,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   thr_type     thr_ff;
   logic        s1_valid_ff;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;
   snap_type    st_ff, st_in;
   snap_type    step;
   logic        s2_valid_ff;
   snap_type    s2_snap_ff;
   logic        sync_ff, sync_in;
   logic        out_free, s2_free, s1_go, s1_free;
   logic        is_digit;
   logic [3:0]  digit;
   verdict_type verdict;
   logic        rsp_valid_ff;
   logic        acc_ff;
   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;

   // Flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || s2_free);
   assign s1_free   = !s1_valid_ff || s1_go;
   assign req_stall = !s1_free;
   assign csr_ready = 1'b1;

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '{year: YEAR_MIN, month: 4'd1, day: 5'd1,
                     hour: 5'd0, minute: 6'd0, second: 6'd0};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THR_YEAR:   thr_ff.year   <= csr_wdata;
            CSR_THR_MONTH:  thr_ff.month  <= csr_wdata[3:0];
            CSR_THR_DAY:    thr_ff.day    <= csr_wdata[4:0];
            CSR_THR_HOUR:   thr_ff.hour   <= csr_wdata[4:0];
            CSR_THR_MINUTE: thr_ff.minute <= csr_wdata[5:0];
            CSR_THR_SECOND: thr_ff.second <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         s1_char_ff <= req_char_in;
         s1_last_ff <= req_last_char;
      end
   end

   // Character check and decimal accumulate
   assign is_digit = (s1_char_ff >= CH_ZERO) && (s1_char_ff <= CH_NINE);
   assign digit    = s1_char_ff[3:0];

   always_comb begin
      step = st_ff;
      case (st_ff.pos) inside
         POS_DASH0, POS_DASH1: step.err = st_ff.err || (s1_char_ff != CH_DASH);
         POS_T:                step.err = st_ff.err || (s1_char_ff != CH_T);
         POS_COL0, POS_COL1:   step.err = st_ff.err || (s1_char_ff != CH_COLON);
         POS_Z:                step.err = st_ff.err || (s1_char_ff != CH_Z);
         default: begin
            if (st_ff.pos < STR_LEN) begin
               if (!is_digit) begin
                  step.err = 1'b1;
               end else if (st_ff.pos <= POS_YEAR_END) begin
                  step.year = (st_ff.year << 3) + (st_ff.year << 1) + {10'd0, digit};
               end else if (st_ff.pos <= POS_MONTH_END) begin
                  step.month = (st_ff.month << 3) + (st_ff.month << 1) + {3'd0, digit};
               end else if (st_ff.pos <= POS_DAY_END) begin
                  step.day = (st_ff.day << 3) + (st_ff.day << 1) + {3'd0, digit};
               end else if (st_ff.pos <= POS_HOUR_END) begin
                  step.hour = (st_ff.hour << 3) + (st_ff.hour << 1) + {3'd0, digit};
               end else if (st_ff.pos <= POS_MINUTE_END) begin
                  step.minute = (st_ff.minute << 3) + (st_ff.minute << 1) + {3'd0, digit};
               end else begin
                  step.second = (st_ff.second << 3) + (st_ff.second << 1) + {3'd0, digit};
               end
            end
         end
      endcase
      if (st_ff.pos < POS_SAT) begin
         step.pos = st_ff.pos + 5'd1;
      end
   end

   // String state: advances per character, clears after the final one
   always_comb begin
      st_in = st_ff;
      if (s1_go) begin
         st_in = s1_last_ff ? '0 : step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   // Parse register: snapshot of a finished string
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_go && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_go && s1_last_ff) begin
         s2_snap_ff <= step;
      end
   end

   itpv_check u_check (
      .snap    (s2_snap_ff),
      .thr     (thr_ff),
      .verdict (verdict)
   );

   // Synchronized flag: only an accepted string moves it
   always_comb begin
      sync_in = sync_ff;
      if (s2_valid_ff && out_free && verdict.ok) begin
         sync_in = verdict.at_or_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= 1'b0;
      end else begin
         sync_ff <= sync_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         acc_ff    <= verdict.ok;
         year_ff   <= verdict.ok ? s2_snap_ff.year[11:0]  : 12'd0;
         month_ff  <= verdict.ok ? s2_snap_ff.month[3:0]  : 4'd0;
         day_ff    <= verdict.ok ? s2_snap_ff.day[4:0]    : 5'd0;
         hour_ff   <= verdict.ok ? s2_snap_ff.hour[4:0]   : 5'd0;
         minute_ff <= verdict.ok ? s2_snap_ff.minute[5:0] : 6'd0;
         second_ff <= verdict.ok ? s2_snap_ff.second[5:0] : 6'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_year_out     = year_ff;
   assign rsp_month_out    = month_ff;
   assign rsp_day_out      = day_ff;
   assign rsp_hour_out     = hour_ff;
   assign rsp_minute_out   = minute_ff;
   assign rsp_second_out   = second_ff;
   assign rsp_synchronized = sync_ff;

   // An accepted result carries an in-range date and time
   a_accepted_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && acc_ff) |-> (year_ff >= 12'd2000 && year_ff <= 12'd2099
         && month_ff >= 4'd1 && month_ff <= 4'd12 && day_ff >= 5'd1
         && hour_ff <= 5'd23 && minute_ff <= 6'd59 && second_ff <= 6'd59))
      else $error("accepted result out of range");

   // A rejected result carries zero fields
   a_rejected_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !acc_ff) |-> (year_ff == 12'd0 && month_ff == 4'd0
         && day_ff == 5'd0 && hour_ff == 5'd0 && minute_ff == 6'd0
         && second_ff == 6'd0))
      else $error("rejected result with nonzero fields");

   // A freshly loaded rejected result leaves the synchronized flag as it was
   a_reject_keeps_sync: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_free && !verdict.ok) |=> $stable(sync_ff))
      else $error("synchronized flag moved on a rejected string");

   // Position never passes its saturation value
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      st_ff.pos <= POS_SAT)
      else $error("character position beyond saturation");

endmodule

// File: dv/timestamp_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and CSR channels of the timestamp parser,
// predicts each result and compares it against what the block returns.
module timestamp_checker
   import itpv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_accepted,
   input  logic [11:0] rsp_year_out,
   input  logic [3:0]  rsp_month_out,
   input  logic [4:0]  rsp_day_out,
   input  logic [4:0]  rsp_hour_out,
   input  logic [5:0]  rsp_minute_out,
   input  logic [5:0]  rsp_second_out,
   input  logic        rsp_synchronized,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata,
   output int          mismatches,
   output int          pending
);

   typedef struct packed {
      logic        accepted;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        sync;
   } stamp_result_type;

   stamp_result_type expected_stamps[$];

   // local copy of the threshold and the parse state
   thr_type     thr;
   logic [4:0]  pos;
   logic        bad;
   logic [13:0] year_acc;
   logic [6:0]  month_acc, day_acc, hour_acc, minute_acc, second_acc;
   logic        sync_flag;

   // Gregorian month length, 0 for a month out of range
   function automatic int month_days(logic [13:0] y, logic [6:0] m);
      logic leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: return 31;
         7'd4, 7'd6, 7'd9, 7'd11: return 30;
         7'd2: return leap ? 29 : 28;
         default: return 0;
      endcase
   endfunction

   task automatic clear_string();
      pos        = '0;
      bad        = 1'b0;
      year_acc   = '0;
      month_acc  = '0;
      day_acc    = '0;
      hour_acc   = '0;
      minute_acc = '0;
      second_acc = '0;
   endtask

   // One character in; on the final character, queue the expected result
   task automatic parse_char(logic [7:0] c, logic last);
      logic [3:0]       d;
      logic             ok;
      stamp_result_type r;
      d = 4'(c - CH_ZERO);
      case (pos)
         POS_DASH0, POS_DASH1: if (c != CH_DASH) bad = 1'b1;
         POS_T:                if (c != CH_T) bad = 1'b1;
         POS_COL0, POS_COL1:   if (c != CH_COLON) bad = 1'b1;
         POS_Z:                if (c != CH_Z) bad = 1'b1;
         default: begin
            // past the twentieth character nothing is checked
            if (pos < STR_LEN) begin
               if (c < CH_ZERO || c > CH_NINE) bad = 1'b1;
               else if (pos <= POS_YEAR_END) year_acc = 14'(year_acc * 10 + d);
               else if (pos <= POS_MONTH_END) month_acc = 7'(month_acc * 10 + d);
               else if (pos <= POS_DAY_END) day_acc = 7'(day_acc * 10 + d);
               else if (pos <= POS_HOUR_END) hour_acc = 7'(hour_acc * 10 + d);
               else if (pos <= POS_MINUTE_END) minute_acc = 7'(minute_acc * 10 + d);
               else second_acc = 7'(second_acc * 10 + d);
            end
         end
      endcase
      if (pos < POS_SAT) pos = pos + 5'd1;

      if (last) begin
         ok = (pos == STR_LEN) && !bad
              && year_acc >= YEAR_MIN && year_acc <= YEAR_MAX
              && month_acc >= 7'd1 && month_acc <= 7'd12
              && day_acc >= 7'd1 && day_acc <= month_days(year_acc, month_acc)
              && hour_acc <= HOUR_MAX && minute_acc <= MINSEC_MAX
              && second_acc <= MINSEC_MAX;
         // fields zero-extended to equal widths compare lexicographically
         if (ok)
            sync_flag = {year_acc, month_acc, day_acc, hour_acc, minute_acc, second_acc}
                        >= {thr.year, 3'b000, thr.month, 2'b00, thr.day, 2'b00, thr.hour,
                            1'b0, thr.minute, 1'b0, thr.second};
         r.accepted = ok;
         r.year     = ok ? year_acc[11:0] : '0;
         r.month    = ok ? month_acc[3:0] : '0;
         r.day      = ok ? day_acc[4:0] : '0;
         r.hour     = ok ? hour_acc[4:0] : '0;
         r.minute   = ok ? minute_acc[5:0] : '0;
         r.second   = ok ? second_acc[5:0] : '0;
         r.sync     = sync_flag;
         expected_stamps.push_back(r);
         clear_string();
      end
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin : monitor
      stamp_result_type exp_r;
      if (reset) begin
         thr.year   = 14'd2000;
         thr.month  = 4'd1;
         thr.day    = 5'd1;
         thr.hour   = 5'd0;
         thr.minute = 6'd0;
         thr.second = 6'd0;
         clear_string();
         sync_flag = 1'b0;
         expected_stamps.delete();
      end else begin
         // threshold writes, masked to register width
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THR_YEAR:   thr.year   = csr_wdata;
               CSR_THR_MONTH:  thr.month  = csr_wdata[3:0];
               CSR_THR_DAY:    thr.day    = csr_wdata[4:0];
               CSR_THR_HOUR:   thr.hour   = csr_wdata[4:0];
               CSR_THR_MINUTE: thr.minute = csr_wdata[5:0];
               CSR_THR_SECOND: thr.second = csr_wdata[5:0];
               default: ;
            endcase
         end

         // result side
         if (rsp_valid && !rsp_stall) begin
            if (expected_stamps.size() == 0) begin
               mismatches++;
               $display("%0t: result with no string pending, actual accepted %0d year %0d",
                        $time, rsp_accepted, rsp_year_out);
            end else begin
               exp_r = expected_stamps.pop_front();
               check_field("accepted", int'(exp_r.accepted), int'(rsp_accepted));
               check_field("year", int'(exp_r.year), int'(rsp_year_out));
               check_field("month", int'(exp_r.month), int'(rsp_month_out));
               check_field("day", int'(exp_r.day), int'(rsp_day_out));
               check_field("hour", int'(exp_r.hour), int'(rsp_hour_out));
               check_field("minute", int'(exp_r.minute), int'(rsp_minute_out));
               check_field("second", int'(exp_r.second), int'(rsp_second_out));
               check_field("synchronized", int'(exp_r.sync), int'(rsp_synchronized));
            end
         end

         // request side
         if (req_valid && !req_stall) parse_char(req_char_in, req_last_char);
      end
      pending <= expected_stamps.size();
   end

endmodule

// File: dv/tb_iso_timestamp_parse_validate.sv
`timescale 1ns / 100ps

module tb_iso_timestamp_parse_validate
   import itpv_pkg::*;
;

   localparam int DRAIN_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = '0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic        rsp_synchronized;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   int          mismatches;
   int          pending;

   logic        quiet = 1'b0;
   int          stall_left = 0;
   logic [7:0]  text_q[$];
   int          chars_sent = 0;
   thr_type     cur_thr = {14'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};

   iso_timestamp_parse_validate uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out),
      .rsp_synchronized (rsp_synchronized),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   timestamp_checker stamp_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out),
      .rsp_synchronized (rsp_synchronized),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always #10 clock = ~clock;

   // Receiver backpressure: a random stall or no-stall level, redrawn when its burst counter runs out
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left <= $urandom_range(0, 8);
      end
   end

   // One character request; optional idle burst after it is taken
   task automatic send_char(logic [7:0] c, logic last);
      req_valid     <= 1'b1;
      req_char_in   <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_queue();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
      chars_sent += text_q.size();
   endtask

   task automatic load_text(string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic send_text(string s);
      load_text(s);
      send_queue();
   endtask

   // Stop sending and wait until every result is back, plus pipeline slack
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // All six threshold registers, then the two unmapped indexes
   task automatic write_thresholds(thr_type t);
      logic [13:0] v;
      for (int i = 0; i < 8; i++) begin
         case (3'(i))
            CSR_THR_YEAR:   v = t.year;
            CSR_THR_MONTH:  v = {10'($urandom), t.month};
            CSR_THR_DAY:    v = {9'($urandom), t.day};
            CSR_THR_HOUR:   v = {9'($urandom), t.hour};
            CSR_THR_MINUTE: v = {8'($urandom), t.minute};
            CSR_THR_SECOND: v = {8'($urandom), t.second};
            default:        v = 14'($urandom);
         endcase
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cur_thr = t;
   endtask

   // Random timestamp, often sharing a prefix with the threshold, sometimes broken
   task automatic make_stamp();
      int   y, mo, d, h, mi, s, n;
      logic same;
      y  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(2000, 2099);
      mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
         0:       d = $urandom_range(0, 99);
         1, 2, 3: d = $urandom_range(28, 31);
         default: d = $urandom_range(1, 31);
      endcase
      h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
      mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
      s  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);

      same = ($urandom_range(0, 2) == 0);
      if (same) y = int'(cur_thr.year);
      same = same && ($urandom_range(0, 3) != 0);
      if (same) mo = int'(cur_thr.month);
      same = same && ($urandom_range(0, 3) != 0);
      if (same) d = int'(cur_thr.day);
      same = same && ($urandom_range(0, 3) != 0);
      if (same) h = int'(cur_thr.hour);
      same = same && ($urandom_range(0, 3) != 0);
      if (same) mi = int'(cur_thr.minute);
      same = same && ($urandom_range(0, 3) != 0);
      if (same) s = int'(cur_thr.second);

      load_text($sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", y, mo, d, h, mi, s));
      case ($urandom_range(0, 9))
         0: text_q[$urandom_range(0, 19)] = 8'($urandom);
         1: begin
            n = $urandom_range(1, 19);
            text_q = text_q[0:n-1];
         end
         2: repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
         3: begin
            text_q.delete();
            repeat ($urandom_range(1, 30)) text_q.push_back(8'($urandom));
         end
         default: ;
      endcase
   endtask

   initial begin
      thr_type th;
      int      goal;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default threshold 2000-01-01T00:00:00
      send_text("1999-12-31T23:59:59Z");   // rejected before any sync
      send_text("2000-01-01T00:00:00Z");   // exactly at threshold
      send_text("2099-12-31T23:59:59Z");
      send_text("2000-02-29T12:30:45Z");   // century leap year
      send_text("2100-02-28T00:00:00Z");
      send_text("2024-02-29T00:00:00Z");
      send_text("2023-02-29T00:00:00Z");
      send_text("2024-02-30T00:00:00Z");
      send_text("2024-04-31T00:00:00Z");
      send_text("2024-00-10T00:00:00Z");
      send_text("2024-13-10T00:00:00Z");
      send_text("2024-06-00T00:00:00Z");
      send_text("2024-06-15T24:00:00Z");
      send_text("2024-06-15T23:60:00Z");
      send_text("2024-06-15T23:59:60Z");
      send_text("9999-99-99T99:99:99Z");
      send_text("2024-06-15T23:59:5");     // short
      send_text("2024-06-15T23:59:59ZZ");  // one too long
      send_text("2024-06-15T23:59:59Z0123456789ABCDEF");
      send_text("Z");
      send_text("2024/06-15T23:59:59Z");
      send_text("2024-06-15 23:59:59Z");
      send_text("2024-06-15T23.59:59Z");
      send_text("2024-06-15T23:59:59z");
      // NUL and an all-ones byte in digit positions
      load_text("2024-06-15T23:59:59Z");
      text_q[8] = 8'h00;
      send_queue();
      load_text("2024-06-15T23:59:59Z");
      text_q[0] = 8'hFF;
      send_queue();

      // Threshold at its maximum: never synchronized
      drain_results();
      write_thresholds({14'h3FFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F});
      send_text("2099-12-31T23:59:59Z");
      send_text("2099-12-31T23:59:5X");

      // Threshold all zero: always synchronized
      drain_results();
      write_thresholds('0);
      send_text("2000-01-01T00:00:00Z");

      // Mid threshold: one second before, equal, one second after, then before again
      drain_results();
      write_thresholds({14'd2050, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30});
      send_text("2050-06-15T12:30:29Z");
      send_text("2050-06-15T12:30:30Z");
      send_text("2050-06-15T12:30:31Z");
      send_text("2050-06-15T12:30:29Z");

      // Random phases, each with its own threshold
      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         th.year   = ($urandom_range(0, 5) == 0) ? 14'($urandom)
                                                 : 14'($urandom_range(2000, 2099));
         th.month  = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
         th.day    = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
         th.hour   = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
         th.minute = ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
         th.second = ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
         write_thresholds(th);
         quiet <= (ph == 3) || (ph == 7);
         goal = chars_sent + 90;
         while (chars_sent < goal) begin
            make_stamp();
            send_queue();
         end
      end

      drain_results();
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
